// File: src/stc_pkg.sv
// Shared types and constants for the sample timestamp converter.
package stc_pkg;

    localparam int SEC_W     = 32;
    localparam int FRAC_W    = 29;
    localparam int NS_W      = 64;
    localparam int OFFS_W    = 32;
    localparam int CNT_W     = 29;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;
    localparam int DVD_W     = 64;
    localparam int DSR_W     = 31;
    localparam int DIV_STEPS = DVD_W;
    localparam int PROD_W    = 60;

    localparam logic [CNT_W-1:0] CNT_RESET   = 29'd44000000;
    localparam logic [29:0]      NS_PER_SEC  = 30'd1000000000;
    localparam logic [DSR_W-1:0] NS_PER_SEC_D = 31'd1000000000;
    localparam logic [DSR_W-1:0] TWO_SEC_D    = 31'd2000000000;

    localparam logic REG_INTERNAL = 1'b0;
    localparam logic REG_EXTERNAL = 1'b1;

    typedef enum logic [1:0] {
        OP_NS_TO_RAW  = 2'd0,
        OP_RAW_TO_NS  = 2'd1,
        OP_ADD_OFFSET = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    // Sideband that rides along the whole pipe.
    typedef struct packed {
        op_t               op;
        logic [CNT_W-1:0]  m;
        logic [SEC_W-1:0]  secs;
        logic [FRAC_W-1:0] frac;
        logic              neg;
        logic [NS_W-1:0]   wide;
    } item_t;

endpackage

// File: src/stc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module stc_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [stc_pkg::DVD_W-1:0] in_dividend,
    input  logic [stc_pkg::DSR_W-1:0] in_divisor,
    input  stc_pkg::item_t            in_side,
    output logic                      out_valid,
    output logic [stc_pkg::DVD_W-1:0] out_quo,
    output logic [stc_pkg::DSR_W-1:0] out_rem,
    output stc_pkg::item_t            out_side
);
    import stc_pkg::*;

    logic [DIV_STEPS-1:0] vld_reg;
    logic [DVD_W-1:0]     word_reg [DIV_STEPS];
    logic [DSR_W-1:0]     rem_reg  [DIV_STEPS];
    logic [DSR_W-1:0]     dsr_reg  [DIV_STEPS];
    item_t                side_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        logic              vld_in;
        logic [DVD_W-1:0]  word_in;
        logic [DSR_W-1:0]  rem_in;
        logic [DSR_W-1:0]  dsr_in;
        item_t             side_in;
        logic [DSR_W:0]    trial;
        logic [DSR_W+1:0]  diff;
        logic              fits;

        if (k == 0)
        begin : g_first
            assign vld_in  = in_valid;
            assign word_in = in_dividend;
            assign rem_in  = '0;
            assign dsr_in  = in_divisor;
            assign side_in = in_side;
        end
        else
        begin : g_next
            assign vld_in  = vld_reg[k-1];
            assign word_in = word_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign dsr_in  = dsr_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, word_in[DVD_W-1]};
        assign diff  = {1'b0, trial} - {2'b0, dsr_in};
        assign fits  = !diff[DSR_W+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (adv)
                vld_reg[k] <= vld_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                word_reg[k] <= {word_in[DVD_W-2:0], fits};
                rem_reg[k]  <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
                dsr_reg[k]  <= dsr_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign out_quo   = word_reg[DIV_STEPS-1];
    assign out_rem   = rem_reg[DIV_STEPS-1];
    assign out_side  = side_reg[DIV_STEPS-1];

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DIV_STEPS-1] |-> rem_reg[DIV_STEPS-1] < dsr_reg[DIV_STEPS-1])
        else $error("divider remainder not below divisor");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("divider valid bits moved while stalled");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && adv |=> dsr_reg[0] != '0)
        else $error("zero divisor entered divider");

endmodule

// File: src/sample_timestamp_converter.sv
// Top level: timestamp conversion between nanoseconds and seconds plus sample count.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | into      | in_valid / in_stall  | opcode clock_mode ns_value in_seconds
//          |           |                      | in_fraction sample_offset
//  out     | out of    | out_valid / out_stall| out_seconds out_fraction out_nanoseconds
//  cfg     | into      | APB psel/penable     | count per second, internal / external
//
// One beat enters per cycle unless out_stall holds the output; the stages are: prep stage,
// 64 stages of the first divider, multiply stage, numerator stage, 64 stages of the second
// divider, output register. The two 64-step restoring dividers set the depth.
// Reset (rst_n low, async) clears valid bits and loads both counts with 44000000.
// A held output beat freezes the whole pipe in place; in_stall follows it directly.
module sample_timestamp_converter (
    input  logic                       clk,
    input  logic                       rst_n,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 opcode,
    input  logic                       clock_mode,
    input  logic [63:0]                ns_value,
    input  logic [31:0]                in_seconds,
    input  logic [28:0]                in_fraction,
    input  logic signed [31:0]         sample_offset,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [31:0]                out_seconds,
    output logic [28:0]                out_fraction,
    output logic [63:0]                out_nanoseconds,
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [stc_pkg::ADDR_W-1:0] paddr,
    input  logic [stc_pkg::DATA_W-1:0] pwdata,
    output logic [stc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import stc_pkg::*;

    // ---------------- configuration registers ----------------
    logic [CNT_W-1:0] int_cnt_reg;
    logic [CNT_W-1:0] ext_cnt_reg;
    logic             cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            int_cnt_reg <= CNT_RESET;
            ext_cnt_reg <= CNT_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_INTERNAL)
                int_cnt_reg <= pwdata[CNT_W-1:0];
            else
                ext_cnt_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_EXTERNAL)
            prdata = {{(DATA_W-CNT_W){1'b0}}, ext_cnt_reg};
        else
            prdata = {{(DATA_W-CNT_W){1'b0}}, int_cnt_reg};
    end

    // ---------------- pipeline advance ----------------
    // Every stage moves together; only a held output beat stops it.
    logic out_valid_reg;
    logic adv;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // ---------------- stage A: operand prep ----------------
    logic [CNT_W-1:0] m_sel;
    logic [CNT_W-1:0] m_eff;
    logic [33:0]      t_sum;
    logic             t_neg;
    logic [33:0]      t_mag;
    logic [61:0]      sec_ns;
    logic [DVD_W-1:0] a_dividend_next;
    logic [DSR_W-1:0] a_divisor_next;
    item_t            a_item_next;

    logic             a_valid_reg;
    logic [DVD_W-1:0] a_dividend_reg;
    logic [DSR_W-1:0] a_divisor_reg;
    item_t            a_item_reg;

    assign m_sel  = clock_mode ? ext_cnt_reg : int_cnt_reg;
    assign m_eff  = (m_sel == '0) ? CNT_W'(1) : m_sel;
    // fraction plus signed offset, exact in 34 bits
    assign t_sum  = {5'b0, in_fraction} + {{2{sample_offset[31]}}, sample_offset};
    assign t_neg  = t_sum[33];
    // for negative t divide -t-1 and fold back afterwards (floor semantics)
    assign t_mag  = t_neg ? ~t_sum : t_sum;
    assign sec_ns = in_seconds * NS_PER_SEC;

    always_comb
    begin
        a_item_next.op   = op_t'(opcode);
        a_item_next.m    = m_eff;
        a_item_next.secs = in_seconds;
        a_item_next.frac = in_fraction;
        a_item_next.neg  = t_neg;
        a_item_next.wide = {2'b0, sec_ns};
        case (op_t'(opcode))
            OP_NS_TO_RAW:
            begin
                a_dividend_next = ns_value;
                a_divisor_next  = NS_PER_SEC_D;
            end
            OP_ADD_OFFSET:
            begin
                a_dividend_next = {{(DVD_W-33){1'b0}}, t_mag[32:0]};
                a_divisor_next  = {{(DSR_W-CNT_W){1'b0}}, m_eff};
            end
            default:
            begin
                a_dividend_next = '0;
                a_divisor_next  = DSR_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (adv)
            a_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_dividend_reg <= a_dividend_next;
            a_divisor_reg  <= a_divisor_next;
            a_item_reg     <= a_item_next;
        end
    end

    // ---------------- divider 1: ns / 1e9, or offset sum / M ----------------
    logic             d1_valid;
    logic [DVD_W-1:0] d1_quo;
    logic [DSR_W-1:0] d1_rem;
    item_t            d1_item;

    stc_div u_div1 (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (a_valid_reg),
        .in_dividend (a_dividend_reg),
        .in_divisor  (a_divisor_reg),
        .in_side     (a_item_reg),
        .out_valid   (d1_valid),
        .out_quo     (d1_quo),
        .out_rem     (d1_rem),
        .out_side    (d1_item)
    );

    // ---------------- stage B: multiply, finish offset add ----------------
    logic [29:0]       mul_a;
    logic [29:0]       mul_b;
    logic [DVD_W-1:0]  q_floor;
    logic [FRAC_W-1:0] r_floor;
    item_t             b_item_next;

    logic              b_valid_reg;
    logic [PROD_W-1:0] b_prod_reg;
    item_t             b_item_reg;

    // op 0: remainder p times M; op 1: fraction times 1e9
    assign mul_a   = (d1_item.op == OP_NS_TO_RAW) ? d1_rem[29:0] : {1'b0, d1_item.frac};
    assign mul_b   = (d1_item.op == OP_NS_TO_RAW) ? {1'b0, d1_item.m} : NS_PER_SEC;
    assign q_floor = d1_item.neg ? ~d1_quo : d1_quo;
    assign r_floor = d1_item.neg ? (d1_item.m - FRAC_W'(1) - d1_rem[FRAC_W-1:0])
                                 : d1_rem[FRAC_W-1:0];

    always_comb
    begin
        b_item_next = d1_item;
        case (d1_item.op)
            OP_NS_TO_RAW:  b_item_next.secs = d1_quo[SEC_W-1:0];
            OP_ADD_OFFSET:
            begin
                b_item_next.secs = d1_item.secs + q_floor[SEC_W-1:0];
                b_item_next.frac = r_floor;
            end
            default:       b_item_next = d1_item;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (adv)
            b_valid_reg <= d1_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_prod_reg <= mul_a * mul_b;
            b_item_reg <= b_item_next;
        end
    end

    // ---------------- stage C: rounding numerator ----------------
    logic [DVD_W-1:0] c_num_next;
    logic [DSR_W-1:0] c_dsr_next;

    logic             c_valid_reg;
    logic [DVD_W-1:0] c_num_reg;
    logic [DSR_W-1:0] c_dsr_reg;
    item_t            c_item_reg;

    always_comb
    begin
        case (b_item_reg.op)
            OP_NS_TO_RAW:
            begin
                // (2pM + 1e9) / 2e9
                c_num_next = {3'b0, b_prod_reg, 1'b0} + {34'b0, NS_PER_SEC};
                c_dsr_next = TWO_SEC_D;
            end
            OP_RAW_TO_NS:
            begin
                // (2 frac 1e9 + M) / 2M
                c_num_next = {3'b0, b_prod_reg, 1'b0} + {35'b0, b_item_reg.m};
                c_dsr_next = {1'b0, b_item_reg.m, 1'b0};
            end
            default:
            begin
                c_num_next = '0;
                c_dsr_next = DSR_W'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (adv)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_num_reg  <= c_num_next;
            c_dsr_reg  <= c_dsr_next;
            c_item_reg <= b_item_reg;
        end
    end

    // ---------------- divider 2: rounded quotient ----------------
    logic             d2_valid;
    logic [DVD_W-1:0] d2_quo;
    logic [DSR_W-1:0] d2_rem;
    item_t            d2_item;

    stc_div u_div2 (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (c_valid_reg),
        .in_dividend (c_num_reg),
        .in_divisor  (c_dsr_reg),
        .in_side     (c_item_reg),
        .out_valid   (d2_valid),
        .out_quo     (d2_quo),
        .out_rem     (d2_rem),
        .out_side    (d2_item)
    );

    // ---------------- output register ----------------
    logic [SEC_W-1:0]  sec_next;
    logic [FRAC_W-1:0] frac_next;
    logic [NS_W-1:0]   ns_next;
    logic [SEC_W-1:0]  out_seconds_reg;
    logic [FRAC_W-1:0] out_fraction_reg;
    logic [NS_W-1:0]   out_ns_reg;

    always_comb
    begin
        sec_next  = '0;
        frac_next = '0;
        ns_next   = '0;
        case (d2_item.op)
            OP_NS_TO_RAW:
            begin
                // a fraction rounded up to a full second carries
                if (d2_quo == {{(DVD_W-CNT_W){1'b0}}, d2_item.m})
                begin
                    sec_next  = d2_item.secs + SEC_W'(1);
                    frac_next = '0;
                end
                else
                begin
                    sec_next  = d2_item.secs;
                    frac_next = d2_quo[FRAC_W-1:0];
                end
            end
            OP_RAW_TO_NS:  ns_next = d2_item.wide + d2_quo;
            OP_ADD_OFFSET:
            begin
                sec_next  = d2_item.secs;
                frac_next = d2_item.frac;
            end
            default:
            begin
                sec_next  = '0;
                frac_next = '0;
                ns_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= d2_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_seconds_reg  <= sec_next;
            out_fraction_reg <= frac_next;
            out_ns_reg       <= ns_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_seconds     = out_seconds_reg;
    assign out_fraction    = out_fraction_reg;
    assign out_nanoseconds = out_ns_reg;

    // ---------------- checks ----------------
    a_ns_excludes_raw: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_nanoseconds != '0) |-> (out_seconds == '0) && (out_fraction == '0))
        else $error("nanosecond result with nonzero raw fields");

    a_round_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        d2_valid && (d2_item.op == OP_NS_TO_RAW)
            |-> d2_quo <= {{(DVD_W-CNT_W){1'b0}}, d2_item.m})
        else $error("rounded fraction above count per second");

    a_offset_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        d1_valid && (d1_item.op == OP_ADD_OFFSET)
            |-> d1_rem < {{(DSR_W-CNT_W){1'b0}}, d1_item.m})
        else $error("offset remainder not below count per second");

    a_rounding_rem_used: assert property (@(posedge clk) disable iff (!rst_n)
        d2_valid |-> d2_rem < DSR_W'(TWO_SEC_D))
        else $error("rounding remainder out of range");

endmodule
